FILE: design/pls_pkg.sv
// Shared types and codes for the positional list store.
// Holds the request/response item structs, operation and status codes.
package pls_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    K_PUSH   = 2'd0,
    K_INSERT = 2'd1,
    K_POP    = 2'd2,
    K_REMOVE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_TAIL = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]   popped_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    wr_en;
    logic    wr_val;
    logic    wr_tail;
    rd_sel_t rd_sel;
    logic    idx_ld_ins;
    logic    idx_ld_rem;
    logic    idx_dec;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_ld;
    logic    res_pop;
    status_t res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  pos_zero;
    logic  pos_gt_count;
    logic  ins_done;
    logic  rem_done;
  } stat_t;

endpackage

FILE: design/positional_list_store.sv
// Positional list store: bounded ordered list with push, insert, pop, remove.
// Handles one item at a time; the cost of insert and remove grows with each
// moved entry, as the shift walk over the entry memory (one read port, one
// write port) moves one entry per CHK/WR state pair.
// Reset clears the count and controller; entry memory is not cleared.
// Depends on pls_pkg, pls_ctrl, pls_dpath.
module positional_list_store #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pls_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pls_pkg::rsp_t rsp
);

  pls_pkg::cmd_t  cmd;
  pls_pkg::stat_t st;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .st        (st),
    .cmd       (cmd)
  );

  pls_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .st  (st),
    .rsp (rsp)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request ready while a response is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
    else $error("controller not busy after accepting an item");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == pls_pkg::ST_FULL) |-> st.full)
    else $error("full status reported while list not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == pls_pkg::ST_EMPTY) |-> st.empty)
    else $error("empty status reported while list holds entries");
`endif

endmodule

FILE: design/pls_dpath.sv
// Datapath of the positional list store: entry memory, count, walk index,
// latched request and result register. Depends on pls_pkg.
module pls_dpath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  pls_pkg::req_t req,
  input  pls_pkg::cmd_t cmd,
  output pls_pkg::stat_t st,
  output pls_pkg::rsp_t rsp
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;
  localparam int unsigned EXTW = (VALUE_WIDTH > pls_pkg::VAL_W) ? VALUE_WIDTH : pls_pkg::VAL_W;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [CW-1:0]          count;
  logic [AW-1:0]          idx;
  pls_pkg::req_t          held;
  logic [1:0]             res_status;
  logic [pls_pkg::VAL_W-1:0] res_popped;

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [EXTW-1:0]        val_ext;
  logic [EXTW-1:0]        rd_ext;
  logic [CMPW-1:0]        pos_w;
  logic [CMPW-1:0]        cnt_w;
  logic [CMPW-1:0]        idx_w;
  logic [CMPW-1:0]        slot_w;
  logic [CMPW-1:0]        pos_m1_w;
  logic [CW-1:0]          cnt_m1;

  assign val_ext  = EXTW'(held.value);
  assign val_in   = val_ext[VALUE_WIDTH-1:0];
  assign rd_ext   = EXTW'(rdata);
  assign pos_w    = CMPW'(held.position);
  assign cnt_w    = CMPW'(count);
  assign idx_w    = CMPW'(idx);
  assign pos_m1_w = pos_w - CMPW'(1);
  assign slot_w   = (pos_w == '0) ? '0 : pos_m1_w;
  assign cnt_m1   = count - CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      pls_pkg::RD_PREV: rd_addr = idx - AW'(1);
      pls_pkg::RD_NEXT: rd_addr = idx + AW'(1);
      default:          rd_addr = cnt_m1[AW-1:0];
    endcase
  end

  assign wr_addr = cmd.wr_tail ? count[AW-1:0] : idx;
  assign wr_data = cmd.wr_val ? val_in : rdata;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held <= req;
    end
    if (cmd.idx_ld_ins) begin
      idx <= count[AW-1:0];
    end else if (cmd.idx_ld_rem) begin
      idx <= pos_m1_w[AW-1:0];
    end else if (cmd.idx_dec) begin
      idx <= idx - AW'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      res_popped <= cmd.res_pop ? rd_ext[pls_pkg::VAL_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= cnt_m1;
    end
  end

  assign st.kind         = pls_pkg::kind_t'(held.kind);
  assign st.full         = (count == CW'(DEPTH));
  assign st.empty        = (count == '0);
  assign st.pos_zero     = (pos_w == '0);
  assign st.pos_gt_count = (pos_w > cnt_w);
  assign st.ins_done     = (idx_w == slot_w);
  assign st.rem_done     = ((idx_w + CMPW'(1)) >= cnt_w);

  assign rsp.popped_value = res_popped;
  assign rsp.status       = res_status;
  assign rsp.entry_count  = cnt_w[pls_pkg::COUNT_W-1:0];

endmodule

FILE: design/pls_ctrl.sv
// Controller of the positional list store: sequences decode, memory
// shifts and the response handshake. Depends on pls_pkg.
module pls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  pls_pkg::stat_t st,
  output pls_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_WR,
    S_REM_CHK,
    S_REM_WR,
    S_POP_WAIT,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = pls_pkg::RD_TAIL;
    cmd.res_status = pls_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.kind)
          pls_pkg::K_PUSH: begin
            cmd.res_ld = 1'b1;
            state_next = S_RESULT;
            if (st.full) begin
              cmd.res_status = pls_pkg::ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_val  = 1'b1;
              cmd.wr_tail = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end
          pls_pkg::K_INSERT: begin
            if (st.full) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = pls_pkg::ST_FULL;
              state_next     = S_RESULT;
            end else if (st.pos_gt_count) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = pls_pkg::ST_RANGE;
              state_next     = S_RESULT;
            end else begin
              cmd.idx_ld_ins = 1'b1;
              state_next     = S_INS_CHK;
            end
          end
          pls_pkg::K_POP: begin
            if (st.empty) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = pls_pkg::ST_EMPTY;
              state_next     = S_RESULT;
            end else begin
              cmd.rd_sel  = pls_pkg::RD_TAIL;
              cmd.cnt_dec = 1'b1;
              state_next  = S_POP_WAIT;
            end
          end
          default: begin
            if (st.empty) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = pls_pkg::ST_EMPTY;
              state_next     = S_RESULT;
            end else if (st.pos_zero || st.pos_gt_count) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = pls_pkg::ST_RANGE;
              state_next     = S_RESULT;
            end else begin
              cmd.idx_ld_rem = 1'b1;
              state_next     = S_REM_CHK;
            end
          end
        endcase
      end
      S_INS_CHK: begin
        if (st.ins_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.res_ld  = 1'b1;
          state_next  = S_RESULT;
        end else begin
          cmd.rd_sel = pls_pkg::RD_PREV;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next  = S_INS_CHK;
      end
      S_REM_CHK: begin
        if (st.rem_done) begin
          cmd.cnt_dec = 1'b1;
          cmd.res_ld  = 1'b1;
          state_next  = S_RESULT;
        end else begin
          cmd.rd_sel = pls_pkg::RD_NEXT;
          state_next = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_REM_CHK;
      end
      S_POP_WAIT: begin
        cmd.res_ld  = 1'b1;
        cmd.res_pop = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
      rsp_valid <= (state_next == S_RESULT);
    end
  end

endmodule
